// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top level of the list store.
// Needs nothing else; the assertions drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- hw/rtl/plsu_pkg.sv -----
// Package of the positional list store: command and status codes, cell control
// types and the controller state type. Depends on nothing.
package plsu_pkg;

  localparam int unsigned IDX_W = 8;
  localparam int unsigned VAL_W = 32;

  localparam logic [2:0] MODE_INS_HEAD = 3'd0;
  localparam logic [2:0] MODE_INS_TAIL = 3'd1;
  localparam logic [2:0] MODE_INS_POS  = 3'd2;
  localparam logic [2:0] MODE_DEL_POS  = 3'd3;
  localparam logic [2:0] MODE_DISPLAY  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef logic [IDX_W-1:0] plsu_idx_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } plsu_cell_op_e;

  typedef struct packed {
    plsu_cell_op_e            op;
    plsu_idx_t                idx;
    logic signed [VAL_W-1:0]  value;
  } plsu_cell_ctrl_t;

  typedef enum logic {
    PLSU_IDLE,
    PLSU_DISPLAY
  } plsu_state_e;

endpackage

// ----- hw/rtl/plsu_cell.sv -----
// One storage cell of the list store chain. It holds one entry and takes its
// next value from itself, a neighbor, the head cell or the new value.
// Depends on plsu_pkg.
module plsu_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                                 clk_i,
  input  plsu_pkg::plsu_cell_ctrl_t            ctrl_i,
  input  logic signed [plsu_pkg::VAL_W-1:0]    left_i,
  input  logic signed [plsu_pkg::VAL_W-1:0]    right_i,
  input  logic signed [plsu_pkg::VAL_W-1:0]    head_i,
  output logic signed [plsu_pkg::VAL_W-1:0]    data_o
);

  localparam plsu_pkg::plsu_idx_t MyIdx = plsu_pkg::plsu_idx_t'(IDX);

  logic signed [plsu_pkg::VAL_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      plsu_pkg::CELL_INS: begin
        if (MyIdx > ctrl_i.idx) begin
          data_d = left_i;
        end else if (MyIdx == ctrl_i.idx) begin
          data_d = ctrl_i.value;
        end
      end
      plsu_pkg::CELL_DEL: begin
        if (MyIdx >= ctrl_i.idx) begin
          data_d = right_i;
        end
      end
      plsu_pkg::CELL_ROT: begin
        if (MyIdx < ctrl_i.idx) begin
          data_d = right_i;
        end else if (MyIdx == ctrl_i.idx) begin
          data_d = head_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- hw/rtl/positional_list_store_unit.sv -----
// Top level of the positional list store: command decode, display sequencer,
// result register and the chain of plsu_cell storage cells.
// Depends on plsu_pkg, plsu_cell and assert_macros.svh.
//
//   channel  direction   handshake                 payload
//   in       into block  in_valid_i/in_stall_o     mode_i, value_i, position_i
//   out      from block  out_valid_o/out_stall_i   value_res_o, status_o, count_o, last_o
//
// Commands other than a display of a nonempty list give one result each.
// A display of N entries is accepted first and then gives one entry per cycle, while the
// output is not stalled, from a rotation of the cell chain, with the input stalled meanwhile.
// Reset clears the entry count and the controller; entries are not cleared.
// A stalled result holds the result register and, with it, the whole block.
`include "assert_macros.svh"

module positional_list_store_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [2:0]                          mode_i,
  input  logic signed [plsu_pkg::VAL_W-1:0]   value_i,
  input  logic [7:0]                          position_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [plsu_pkg::VAL_W-1:0]   value_res_o,
  output logic [1:0]                          status_o,
  output logic [4:0]                          count_o,
  output logic                                last_o
);

  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned IW  = $clog2(DEPTH);
  localparam int unsigned PW  = ((CW > 8) ? CW : 8) + 1;
  localparam int unsigned CXW = (CW > 5) ? CW : 5;

  plsu_pkg::plsu_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rd_q, rd_d;

  logic                                out_valid_q, out_valid_d;
  logic signed [plsu_pkg::VAL_W-1:0]   value_res_q, value_res_d;
  logic [1:0]                          status_q, status_d;
  logic [4:0]                          count_res_q, count_res_d;
  logic                                last_q, last_d;

  plsu_pkg::plsu_cell_ctrl_t         cell_ctrl;
  logic signed [plsu_pkg::VAL_W-1:0] cell_data [DEPTH];

  logic          out_free;
  logic          in_acc;
  logic          full;
  logic [PW-1:0] pos_x, cnt_x;
  logic          ins_ok, del_ok;
  logic [IW-1:0] pos_idx, tail_idx, rot_idx;
  logic [CXW-1:0] cnt_ext;
  logic          ins_mode;
  logic          disp_mode;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != plsu_pkg::PLSU_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign full     = (count_q == CW'(DEPTH));
  assign pos_x    = PW'(position_i);
  assign cnt_x    = PW'(count_q);
  assign ins_ok   = (pos_x != '0) && (pos_x <= cnt_x + PW'(1));
  assign del_ok   = (pos_x != '0) && (pos_x <= cnt_x);
  assign pos_idx  = IW'(pos_x - PW'(1));
  assign tail_idx = count_q[IW-1:0];
  assign rot_idx  = IW'(count_q - CW'(1));

  assign ins_mode  = mode_i inside {plsu_pkg::MODE_INS_HEAD, plsu_pkg::MODE_INS_TAIL,
                                    plsu_pkg::MODE_INS_POS};
  assign disp_mode = (mode_i == plsu_pkg::MODE_DISPLAY);

  always_comb begin
    state_d = state_q;
    case (state_q)
      plsu_pkg::PLSU_IDLE: begin
        if (in_acc && (mode_i == plsu_pkg::MODE_DISPLAY) && (count_q != '0)) begin
          state_d = plsu_pkg::PLSU_DISPLAY;
        end
      end
      plsu_pkg::PLSU_DISPLAY: begin
        if (out_free && (rd_q == CW'(1))) begin
          state_d = plsu_pkg::PLSU_IDLE;
        end
      end
      default: state_d = plsu_pkg::PLSU_IDLE;
    endcase
  end

  always_comb begin
    cell_ctrl.op    = plsu_pkg::CELL_HOLD;
    cell_ctrl.idx   = '0;
    cell_ctrl.value = value_i;
    count_d         = count_q;
    rd_d            = rd_q;
    out_valid_d     = out_free ? 1'b0 : out_valid_q;
    value_res_d     = value_res_q;
    status_d        = status_q;
    last_d          = last_q;
    case (state_q)
      plsu_pkg::PLSU_IDLE: begin
        if (in_acc) begin
          out_valid_d = 1'b1;
          value_res_d = '0;
          status_d    = plsu_pkg::ST_OK;
          last_d      = 1'b1;
          case (mode_i)
            plsu_pkg::MODE_INS_HEAD, plsu_pkg::MODE_INS_TAIL, plsu_pkg::MODE_INS_POS: begin
              if (full) begin
                status_d = plsu_pkg::ST_FULL;
              end else if ((mode_i == plsu_pkg::MODE_INS_POS) && !ins_ok) begin
                status_d = plsu_pkg::ST_RANGE;
              end else begin
                cell_ctrl.op = plsu_pkg::CELL_INS;
                if (mode_i == plsu_pkg::MODE_INS_HEAD) begin
                  cell_ctrl.idx = '0;
                end else if (mode_i == plsu_pkg::MODE_INS_TAIL) begin
                  cell_ctrl.idx = plsu_pkg::plsu_idx_t'(tail_idx);
                end else begin
                  cell_ctrl.idx = plsu_pkg::plsu_idx_t'(pos_idx);
                end
                count_d = count_q + CW'(1);
              end
            end
            plsu_pkg::MODE_DEL_POS: begin
              if (!del_ok) begin
                status_d = plsu_pkg::ST_RANGE;
              end else begin
                cell_ctrl.op  = plsu_pkg::CELL_DEL;
                cell_ctrl.idx = plsu_pkg::plsu_idx_t'(pos_idx);
                count_d       = count_q - CW'(1);
              end
            end
            plsu_pkg::MODE_DISPLAY: begin
              if (count_q == '0) begin
                status_d = plsu_pkg::ST_EMPTY;
              end else begin
                out_valid_d = 1'b0;
                rd_d        = count_q;
              end
            end
            default: status_d = plsu_pkg::ST_OK;
          endcase
        end
      end
      plsu_pkg::PLSU_DISPLAY: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          value_res_d   = cell_data[0];
          status_d      = plsu_pkg::ST_OK;
          last_d        = (rd_q == CW'(1));
          rd_d          = rd_q - CW'(1);
          cell_ctrl.op  = plsu_pkg::CELL_ROT;
          cell_ctrl.idx = plsu_pkg::plsu_idx_t'(rot_idx);
        end
      end
      default: cell_ctrl.op = plsu_pkg::CELL_HOLD;
    endcase
  end

  assign cnt_ext     = CXW'(count_d);
  assign count_res_d = out_free ? cnt_ext[4:0] : count_res_q;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [plsu_pkg::VAL_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = cell_data[g];
    end else begin : g_left
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_right
      assign right_w = cell_data[g+1];
    end
    plsu_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl),
      .left_i (left_w),
      .right_i(right_w),
      .head_i (cell_data[0]),
      .data_o (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plsu_pkg::PLSU_IDLE;
      count_q     <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_res_q <= value_res_d;
    status_q    <= status_d;
    count_res_q <= count_res_d;
    last_q      <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_res_o = value_res_q;
  assign status_o    = status_q;
  assign count_o     = count_res_q;
  assign last_o      = last_q;

  `ASSERT_CLK(a_count_bound, clk_i, rst_ni, count_q <= CW'(DEPTH))
  `ASSERT_NEXT(a_count_only_on_cmd, clk_i, rst_ni, !in_acc, $stable(count_q))
  `ASSERT_NEXT(a_cmd_result, clk_i, rst_ni, in_acc && !disp_mode, out_valid_o && last_o)
  `ASSERT_NEXT(a_full_insert, clk_i, rst_ni, in_acc && full && ins_mode, status_o == plsu_pkg::ST_FULL)
  `ASSERT_CLK(a_display_pending, clk_i, rst_ni, (state_q != plsu_pkg::PLSU_DISPLAY) || (rd_q != '0))

endmodule
